@@ rtl/hfm_pkg.sv @@
package hfm_pkg;

    // encoder and position
    localparam int unsigned ENC_BITS   = 14;
    localparam int unsigned POS_W      = 10;
    localparam int unsigned POS_MAX    = 720;
    // floor(x / 91) for x < 2^16, with x = word << 2, as (word * POS_MUL) >> POS_SHIFT
    localparam int unsigned POS_MUL    = 11799361;
    localparam int unsigned POS_MUL_W  = 24;
    localparam int unsigned POS_SHIFT  = 28;
    localparam int unsigned POS_PROD_W = ENC_BITS + POS_MUL_W;

    // texture
    localparam int unsigned TEXTURE_PERIOD = 45;
    localparam int unsigned DIV_SHIFT      = 20;
    localparam int unsigned RECIP          = (2**DIV_SHIFT + TEXTURE_PERIOD - 1) / TEXTURE_PERIOD;
    localparam int unsigned REC_W          = $clog2(RECIP + 1);
    localparam int unsigned Q_W            = $clog2(POS_MAX / TEXTURE_PERIOD + 1);
    localparam int unsigned M_W            = $clog2(TEXTURE_PERIOD);

    // wall
    localparam logic [15:0] WALL_RAMP     = 16'd16;
    localparam logic [14:0] WALL_FULL     = 15'h7fff;
    localparam logic [15:0] WALL_POS_FULL = 16'h7fff;
    localparam logic [15:0] WALL_NEG_FULL = 16'h8001;

    // enable bit positions in term_enables
    localparam int unsigned EN_SPRING  = 3;
    localparam int unsigned EN_DAMPER  = 2;
    localparam int unsigned EN_WALL    = 1;
    localparam int unsigned EN_TEXTURE = 0;

    typedef enum logic [2:0] {
        CFG_TERM_ENABLES = 3'd0,
        CFG_WALL_LEFT    = 3'd1,
        CFG_WALL_RIGHT   = 3'd2,
        CFG_SPRING_REST  = 3'd3,
        CFG_SPRING_GAIN  = 3'd4,
        CFG_DAMPER_GAIN  = 3'd5,
        CFG_TEXTURE_GAIN = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic        [15:0] encoder_word;
        logic signed [15:0] velocity;
    } t_item;

    typedef struct packed {
        logic [15:0] drive_forward;
        logic [15:0] drive_reverse;
    } t_result;

    // quarter-wave q1.15 sine, round(32767*sin(k*pi/128))
    localparam logic [14:0] QSINE [65] = '{
        15'd0,     15'd804,   15'd1608,  15'd2410,  15'd3212,  15'd4011,  15'd4808,  15'd5602,
        15'd6393,  15'd7179,  15'd7962,  15'd8739,  15'd9512,  15'd10278, 15'd11039, 15'd11793,
        15'd12539, 15'd13279, 15'd14010, 15'd14732, 15'd15446, 15'd16151, 15'd16846, 15'd17530,
        15'd18204, 15'd18868, 15'd19519, 15'd20166, 15'd20787, 15'd21403, 15'd22005, 15'd22594,
        15'd23170, 15'd23731, 15'd24279, 15'd24811, 15'd25329, 15'd25832, 15'd26319, 15'd26790,
        15'd27245, 15'd27683, 15'd28105, 15'd28510, 15'd28898, 15'd29268, 15'd29621, 15'd29956,
        15'd30273, 15'd30571, 15'd30852, 15'd31113, 15'd31356, 15'd31580, 15'd31785, 15'd31971,
        15'd32137, 15'd32285, 15'd32412, 15'd32521, 15'd32609, 15'd32678, 15'd32728, 15'd32757,
        15'd32767
    };

    // entry: bit 15 sign, bits 14:0 magnitude of the sine for each texture remainder
    typedef logic [15:0] t_tex_tab [TEXTURE_PERIOD];

    function automatic t_tex_tab build_tex_tab();
        t_tex_tab    tab;
        int unsigned ph;
        int unsigned r;
        int unsigned qd;
        logic [14:0] mag;
        for (int unsigned i = 0; i < TEXTURE_PERIOD; i++) begin
            ph  = ((i * 256 + TEXTURE_PERIOD / 2) / TEXTURE_PERIOD) % 256;
            r   = ph % 64;
            qd  = ph / 64;
            mag = (qd % 2 == 1) ? QSINE[64 - r] : QSINE[r];
            tab[i] = {(qd >= 2), mag};
        end
        return tab;
    endfunction

    localparam t_tex_tab TEX_TAB = build_tex_tab();

    // doubling ramp near a wall edge, saturated at full scale
    function automatic logic [14:0] ramp_mag(input logic [15:0] d);
        logic [14:0] m;
        if (d >= 16'd15) begin
            m = WALL_FULL;
        end else begin
            m = 15'd1 << d[3:0];
        end
        return m;
    endfunction

endpackage

@@ rtl/haptic_force_mixer_core.sv @@
// haptic force mixer core
//
// input: pulse start with i_item (encoder word and velocity); busy is never
// raised, so a new sample can be issued every cycle.
// output: o_res_valid strobes for one cycle with o_result holding the two
// h-bridge duties; results come out in request order and must be taken
// on the cycle they appear.
// pipeline: throughput one sample per cycle. the stages are: position
// reciprocal multiply and damper multiply, spring multiply and texture
// quotient, texture table and wall ramp, texture multiply and term sum,
// wall override and duty formatting.
// configuration: i_cfg_valid/o_cfg_ready with a register index and data;
// ready is always high, the write lands at that edge. write only while no
// sample is in flight. unknown indexes are ignored.
// reset (synchronous, active low) empties the pipeline and loads the
// register defaults: enables 11, edges 100 and 620, rest 604, spring gain
// 50, damper gain -10, texture gain 17000.
module haptic_force_mixer_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  hfm_pkg::t_item     i_item,
    output logic               o_res_valid,
    output hfm_pkg::t_result   o_result,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    // configuration registers
    logic [3:0]  r_term_enables;
    logic [15:0] r_wall_left;
    logic [15:0] r_wall_right;
    logic [15:0] r_spring_rest;
    logic [15:0] r_spring_gain;
    logic [15:0] r_damper_gain;
    logic [14:0] r_texture_gain;

    logic        cfg_we;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term_enables <= 4'd11;
            r_wall_left    <= 16'd100;
            r_wall_right   <= 16'd620;
            r_spring_rest  <= 16'd604;
            r_spring_gain  <= 16'd50;
            r_damper_gain  <= 16'hfff6;
            r_texture_gain <= 15'd17000;
        end else if (cfg_we) begin
            unique case (hfm_pkg::t_cfg_idx'(i_cfg_index))
                hfm_pkg::CFG_TERM_ENABLES: r_term_enables <= i_cfg_data[3:0];
                hfm_pkg::CFG_WALL_LEFT:    r_wall_left    <= i_cfg_data;
                hfm_pkg::CFG_WALL_RIGHT:   r_wall_right   <= i_cfg_data;
                hfm_pkg::CFG_SPRING_REST:  r_spring_rest  <= i_cfg_data;
                hfm_pkg::CFG_SPRING_GAIN:  r_spring_gain  <= i_cfg_data;
                hfm_pkg::CFG_DAMPER_GAIN:  r_damper_gain  <= i_cfg_data;
                hfm_pkg::CFG_TEXTURE_GAIN: r_texture_gain <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // valid bits
    logic r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid, r_res_valid;
    logic accept;

    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_s1_valid  <= accept;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_s4_valid  <= r_s3_valid;
            r_res_valid <= r_s4_valid;
        end
    end

    // stage 1: position by reciprocal multiply, damper product
    logic [hfm_pkg::POS_PROD_W-1:0] s1_pos_prod;
    logic [15:0]                    s1_vel;
    logic [31:0]                    s1_damp_prod;
    logic [hfm_pkg::POS_W-1:0]      r_s1_pos;
    logic [15:0]                    r_s1_damp;

    assign s1_pos_prod  = hfm_pkg::POS_PROD_W'(i_item.encoder_word[hfm_pkg::ENC_BITS-1:0])
                        * hfm_pkg::POS_PROD_W'(hfm_pkg::POS_MUL);
    assign s1_vel       = i_item.velocity;
    assign s1_damp_prod = {16'd0, s1_vel} * {16'd0, r_damper_gain};

    always_ff @(posedge i_clk) begin
        r_s1_pos  <= s1_pos_prod[hfm_pkg::POS_SHIFT +: hfm_pkg::POS_W];
        r_s1_damp <= s1_damp_prod[15:0];
    end

    // stage 2: spring product, texture quotient
    localparam int unsigned QP_W = hfm_pkg::POS_W + hfm_pkg::REC_W;

    logic [15:0]               s2_spring_diff;
    logic [31:0]               s2_spring_prod;
    logic [QP_W-1:0]           s2_q_prod;
    logic [hfm_pkg::POS_W-1:0] r_s2_pos;
    logic [hfm_pkg::Q_W-1:0]   r_s2_q;
    logic [15:0]               r_s2_spring;
    logic [15:0]               r_s2_damp;

    assign s2_spring_diff = 16'(r_s1_pos) - r_spring_rest;
    assign s2_spring_prod = {16'd0, r_spring_gain} * {16'd0, s2_spring_diff};
    assign s2_q_prod      = QP_W'(r_s1_pos) * QP_W'(hfm_pkg::RECIP);

    always_ff @(posedge i_clk) begin
        r_s2_pos    <= r_s1_pos;
        r_s2_q      <= s2_q_prod[hfm_pkg::DIV_SHIFT +: hfm_pkg::Q_W];
        r_s2_spring <= s2_spring_prod[15:0];
        r_s2_damp   <= r_s1_damp;
    end

    // stage 3: texture remainder and sine lookup, wall term
    logic [hfm_pkg::POS_W-1:0] s3_qp;
    logic [hfm_pkg::POS_W-1:0] s3_m_full;
    logic [hfm_pkg::M_W-1:0]   s3_m;
    logic [15:0]               s3_sine;
    logic [15:0]               s3_pos;
    logic [15:0]               s3_bl;
    logic [15:0]               s3_br;
    logic [15:0]               s3_wall;
    logic [14:0]               r_s3_smag;
    logic                      r_s3_sneg;
    logic [15:0]               r_s3_wall;
    logic [15:0]               r_s3_spring;
    logic [15:0]               r_s3_damp;

    assign s3_qp     = hfm_pkg::POS_W'(r_s2_q) * hfm_pkg::POS_W'(hfm_pkg::TEXTURE_PERIOD);
    assign s3_m_full = r_s2_pos - s3_qp;
    assign s3_m      = s3_m_full[hfm_pkg::M_W-1:0];
    assign s3_sine   = hfm_pkg::TEX_TAB[s3_m];
    assign s3_pos    = 16'(r_s2_pos);
    assign s3_bl     = r_wall_left + hfm_pkg::WALL_RAMP;
    assign s3_br     = r_wall_right - hfm_pkg::WALL_RAMP;

    always_comb begin
        priority if (s3_pos < r_wall_left) begin
            s3_wall = hfm_pkg::WALL_NEG_FULL;
        end else if (s3_pos < s3_bl) begin
            s3_wall = 16'd0 - {1'b0, hfm_pkg::ramp_mag(s3_bl - s3_pos)};
        end else if (s3_pos > r_wall_right) begin
            s3_wall = hfm_pkg::WALL_POS_FULL;
        end else if (s3_pos > s3_br) begin
            s3_wall = {1'b0, hfm_pkg::ramp_mag(s3_pos - s3_br)};
        end else begin
            s3_wall = 16'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_smag   <= s3_sine[14:0];
        r_s3_sneg   <= s3_sine[15];
        r_s3_wall   <= s3_wall;
        r_s3_spring <= r_s2_spring;
        r_s3_damp   <= r_s2_damp;
    end

    // stage 4: texture scaling and term sum
    logic [29:0] s4_tex_prod;
    logic [15:0] s4_tex_mag;
    logic [15:0] s4_tex;
    logic [15:0] s4_sum;
    logic [15:0] r_s4_sum;
    logic [15:0] r_s4_wall;

    assign s4_tex_prod = {15'd0, r_s3_smag} * {15'd0, r_texture_gain};
    assign s4_tex_mag  = {1'b0, s4_tex_prod[29:15]};
    assign s4_tex      = r_s3_sneg ? (16'd0 - s4_tex_mag) : s4_tex_mag;
    assign s4_sum      = (r_term_enables[hfm_pkg::EN_SPRING]  ? r_s3_spring : 16'd0)
                       + (r_term_enables[hfm_pkg::EN_DAMPER]  ? r_s3_damp   : 16'd0)
                       + (r_term_enables[hfm_pkg::EN_TEXTURE] ? s4_tex      : 16'd0);

    always_ff @(posedge i_clk) begin
        r_s4_sum  <= s4_sum;
        r_s4_wall <= r_s3_wall;
    end

    // stage 5: wall override, duty formatting
    logic [16:0]            s5_sum_ext;
    logic [16:0]            s5_wall_ext;
    logic [16:0]            s5_sum_abs;
    logic [16:0]            s5_wall_abs;
    logic [15:0]            s5_force;
    logic [15:0]            s5_force_neg;
    hfm_pkg::t_result       s5_res;
    hfm_pkg::t_result       r_res;

    assign s5_sum_ext  = {r_s4_sum[15], r_s4_sum};
    assign s5_wall_ext = {r_s4_wall[15], r_s4_wall};
    assign s5_sum_abs  = r_s4_sum[15]  ? (17'd0 - s5_sum_ext)  : s5_sum_ext;
    assign s5_wall_abs = r_s4_wall[15] ? (17'd0 - s5_wall_ext) : s5_wall_ext;

    always_comb begin
        if (r_term_enables[hfm_pkg::EN_WALL] && (s5_wall_abs > s5_sum_abs)) begin
            s5_force = r_s4_wall;
        end else begin
            s5_force = r_s4_sum;
        end
        s5_force_neg = 16'd0 - s5_force;
        if (!s5_force[15] && (s5_force != 16'd0)) begin
            s5_res.drive_forward = {s5_force[14:0], 1'b0};
            s5_res.drive_reverse = 16'd0;
        end else begin
            s5_res.drive_forward = 16'd0;
            s5_res.drive_reverse = {s5_force_neg[14:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= s5_res;
    end

    assign o_res_valid = r_res_valid;
    assign o_result    = r_res;

    // every accepted sample comes out as a result strobe
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##5 o_res_valid)
        else $error("result strobe missing five cycles after request");

    // reciprocal divide keeps the position in range
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> (r_s1_pos <= hfm_pkg::POS_W'(hfm_pkg::POS_MAX)))
        else $error("position out of range");

    // texture remainder stays below the period
    a_tex_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid |-> (s3_m_full < hfm_pkg::POS_W'(hfm_pkg::TEXTURE_PERIOD)))
        else $error("texture remainder out of range");

    // at most one bridge side driven
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_result.drive_forward == 16'd0 || o_result.drive_reverse == 16'd0))
        else $error("both bridge duties nonzero");

endmodule

@@ test/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          POS_DIV      = 91;
    localparam int          FULL_PUSH    = 32767;
    localparam logic [15:0] EDGE_RAMP    = 16'd16;
    localparam logic [2:0]  CFG_UNUSED   = 3'd7;
    localparam int          RANDOM_SETS  = 16;
    localparam int          SET_SAMPLES  = 80;
    localparam int          IDLE_MIX [3] = '{0, 48, 28};
    localparam int          PROBE_POS [14] = '{0, 99, 100, 101, 114, 115, 116,
                                               360, 604, 605, 619, 620, 621, 720};

    // q1.15 quarter wave, 256 steps per turn
    localparam int SINE_QUARTER [65] = '{
        0, 804, 1608, 2410, 3212, 4011, 4808, 5602,
        6393, 7179, 7962, 8739, 9512, 10278, 11039, 11793,
        12539, 13279, 14010, 14732, 15446, 16151, 16846, 17530,
        18204, 18868, 19519, 20166, 20787, 21403, 22005, 22594,
        23170, 23731, 24279, 24811, 25329, 25832, 26319, 26790,
        27245, 27683, 28105, 28510, 28898, 29268, 29621, 29956,
        30273, 30571, 30852, 31113, 31356, 31580, 31785, 31971,
        32137, 32285, 32412, 32521, 32609, 32678, 32728, 32757,
        32767
    };

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             start       = 1'b0;
    hfm_pkg::t_item   i_item      = '0;
    logic             i_cfg_valid = 1'b0;
    logic [2:0]       i_cfg_index = '0;
    logic [15:0]      i_cfg_data  = '0;
    logic             busy;
    logic             o_res_valid;
    hfm_pkg::t_result o_result;
    logic             o_cfg_ready;

    // register shadow, loaded with the reset defaults
    logic [3:0]  en_mask     = 4'd11;
    logic [15:0] wall_left   = 16'd100;
    logic [15:0] wall_right  = 16'd620;
    logic [15:0] spring_rest = 16'd604;
    logic [15:0] spring_k    = 16'd50;
    logic [15:0] damper_k    = 16'hfff6;
    logic [14:0] texture_k   = 15'd17000;

    hfm_pkg::t_item   sample_queue [$];
    hfm_pkg::t_result duty_expected [$];
    hfm_pkg::t_result duty_want;
    int               sender_idle_pct = 0;
    int               mismatch_count  = 0;
    int               cycle_count     = 0;

    haptic_force_mixer_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_res_valid (o_res_valid),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic hfm_pkg::t_result mix_drive(hfm_pkg::t_item s);
        hfm_pkg::t_result r;
        int          pos;
        int          m;
        int          phase;
        int          quad;
        int          sine;
        int          tex;
        int          net_force;
        int          wall_push;
        logic [15:0] dpos;
        logic [15:0] sum;
        logic [15:0] bl;
        logic [15:0] br;
        pos = int'({s.encoder_word[13:0], 2'b00}) / POS_DIV;
        sum = '0;
        if (en_mask[hfm_pkg::EN_SPRING]) begin
            dpos = pos[15:0] - spring_rest;
            sum  = sum + spring_k * dpos;
        end
        if (en_mask[hfm_pkg::EN_DAMPER]) begin
            sum = sum + s.velocity * damper_k;
        end
        if (en_mask[hfm_pkg::EN_TEXTURE]) begin
            m     = pos % hfm_pkg::TEXTURE_PERIOD;
            phase = ((m * 256 + hfm_pkg::TEXTURE_PERIOD / 2) / hfm_pkg::TEXTURE_PERIOD) % 256;
            quad  = phase / 64;
            sine  = (quad % 2 == 1) ? SINE_QUARTER[64 - phase % 64] : SINE_QUARTER[phase % 64];
            tex   = (sine * int'(texture_k)) >>> 15;
            if (quad >= 2) tex = -tex;
            sum = sum + tex[15:0];
        end
        net_force = int'($signed(sum));
        if (en_mask[hfm_pkg::EN_WALL]) begin
            bl = wall_left + EDGE_RAMP;
            br = wall_right - EDGE_RAMP;
            if (pos < int'(wall_left)) begin
                wall_push = -FULL_PUSH;
            end else if (pos < int'(bl)) begin
                wall_push = (int'(bl) - pos >= 15) ? -FULL_PUSH : -(1 << (int'(bl) - pos));
            end else if (pos > int'(wall_right)) begin
                wall_push = FULL_PUSH;
            end else if (pos > int'(br)) begin
                wall_push = (pos - int'(br) >= 15) ? FULL_PUSH : (1 << (pos - int'(br)));
            end else begin
                wall_push = 0;
            end
            // -32768 has magnitude 32768, so it always keeps the sum
            if ((wall_push < 0 ? -wall_push : wall_push) >
                (net_force < 0 ? -net_force : net_force))
                net_force = wall_push;
        end
        if (net_force > 0) begin
            r.drive_forward = 16'(net_force * 2);
            r.drive_reverse = '0;
        end else begin
            r.drive_forward = '0;
            r.drive_reverse = 16'(-net_force * 2);
        end
        return r;
    endfunction

    // encoder word that decodes to position p, top bits are don't-care
    function automatic logic [15:0] enc_for_pos(int p);
        logic [15:0] w;
        w = 16'((p * POS_DIV + 3) / 4);
        w[15:14] = 2'($urandom_range(3));
        return w;
    endfunction

    function automatic hfm_pkg::t_item random_sample();
        hfm_pkg::t_item s;
        int    anchor;
        int    p;
        if ($urandom_range(3) == 0) begin
            s.encoder_word = 16'($urandom);
        end else begin
            case ($urandom_range(2))
                0: anchor = int'(wall_left);
                1: anchor = int'(wall_right);
                default: anchor = int'(spring_rest);
            endcase
            if (anchor > 740) anchor = int'($urandom_range(720));
            p = anchor + int'($urandom_range(40)) - 20;
            if (p < 0) p = 0;
            if (p > 720) p = 720;
            s.encoder_word = enc_for_pos(p);
        end
        case ($urandom_range(7))
            0: s.velocity = 16'h8000;
            1: s.velocity = 16'h7fff;
            2: s.velocity = 16'(int'($urandom_range(8)) - 4);
            default: s.velocity = 16'($urandom);
        endcase
        return s;
    endfunction

    function automatic logic [15:0] rand_gain();
        logic [15:0] g;
        if ($urandom_range(1) == 0) begin
            g = 16'($urandom);
        end else begin
            g = 16'($urandom_range(63));
            if ($urandom_range(1) == 0) g = -g;
        end
        return g;
    endfunction

    task automatic note_failure(string msg);
        mismatch_count++;
        if (mismatch_count <= 10) $display("mismatch: %s", msg);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            hfm_pkg::CFG_TERM_ENABLES: en_mask     = data[3:0];
            hfm_pkg::CFG_WALL_LEFT:    wall_left   = data;
            hfm_pkg::CFG_WALL_RIGHT:   wall_right  = data;
            hfm_pkg::CFG_SPRING_REST:  spring_rest = data;
            hfm_pkg::CFG_SPRING_GAIN:  spring_k    = data;
            hfm_pkg::CFG_DAMPER_GAIN:  damper_k    = data;
            hfm_pkg::CFG_TEXTURE_GAIN: texture_k   = data[14:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [15:0] en, lft, rgt, rest, ks, kd, kt);
        write_reg(hfm_pkg::CFG_TERM_ENABLES, en);
        write_reg(hfm_pkg::CFG_WALL_LEFT, lft);
        write_reg(hfm_pkg::CFG_WALL_RIGHT, rgt);
        write_reg(hfm_pkg::CFG_SPRING_REST, rest);
        write_reg(hfm_pkg::CFG_SPRING_GAIN, ks);
        write_reg(hfm_pkg::CFG_DAMPER_GAIN, kd);
        write_reg(hfm_pkg::CFG_TEXTURE_GAIN, kt);
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (sample_queue.size() != 0 || start || duty_expected.size() != 0);
    endtask

    task automatic run_samples(int count, int idle);
        @(negedge i_clk);
        sender_idle_pct = idle;
        repeat (count) sample_queue.push_back(random_sample());
        wait_drained();
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) duty_expected.push_back(mix_drive(i_item));
            if (!start || !busy) begin
                if (sample_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    start  <= 1'b1;
                    i_item <= sample_queue.pop_front();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid) begin
            if (duty_expected.size() == 0) begin
                note_failure($sformatf("unexpected result fwd=%h rev=%h",
                                       o_result.drive_forward, o_result.drive_reverse));
            end else begin
                duty_want = duty_expected.pop_front();
                if (o_result.drive_forward !== duty_want.drive_forward)
                    note_failure($sformatf("drive_forward expected %h got %h",
                                           duty_want.drive_forward, o_result.drive_forward));
                if (o_result.drive_reverse !== duty_want.drive_reverse)
                    note_failure($sformatf("drive_reverse expected %h got %h",
                                           duty_want.drive_reverse, o_result.drive_reverse));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults: wall ramps, saturation, encoder and velocity extremes
        @(negedge i_clk);
        foreach (PROBE_POS[i]) sample_queue.push_back({enc_for_pos(PROBE_POS[i]), 16'($urandom)});
        sample_queue.push_back({16'hffff, 16'h7fff});
        sample_queue.push_back({16'hc000, 16'h8000});
        sample_queue.push_back({16'h3fff, 16'h0000});
        wait_drained();

        // damper sum of -32768 against a full wall, then one step short of it
        apply_settings(16'h0006, 16'd200, 16'd500, 16'd0, 16'd3, 16'd1, 16'd1000);
        @(negedge i_clk);
        sample_queue.push_back({enc_for_pos(0), 16'h8000});
        sample_queue.push_back({enc_for_pos(0), 16'h8001});
        wait_drained();

        // a write to an unused index must change nothing
        write_reg(CFG_UNUSED, 16'hffff);
        @(negedge i_clk);
        sample_queue.push_back({enc_for_pos(300), 16'h1234});
        wait_drained();

        // upper enable bits are dropped, so every term is off
        write_reg(hfm_pkg::CFG_TERM_ENABLES, 16'hfff0);
        @(negedge i_clk);
        sample_queue.push_back({enc_for_pos(50), 16'($urandom)});
        wait_drained();

        for (int set = 0; set < RANDOM_SETS; set++) begin
            if (set == 0) begin
                apply_settings(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                               16'hffff);
            end else if (set == 1) begin
                apply_settings(16'h000f, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h8000,
                               16'h0000);
            end else begin
                apply_settings(($urandom_range(2) == 0) ? 16'h000f : 16'($urandom),
                               ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(720)),
                               ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(720)),
                               ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(720)),
                               rand_gain(), rand_gain(), 16'($urandom));
            end
            run_samples(SET_SAMPLES, IDLE_MIX[set % 3]);
        end

        // catch any stray result after the last one
        repeat (12) @(posedge i_clk);
        if (mismatch_count == 0 && duty_expected.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/hfm_pkg.sv
rtl/haptic_force_mixer_core.sv
test/tb_top.sv
